// ===== rtl/wavp_pkg.sv =====
// Shared types, tags, phase and status codes for the WAV header parser.
package wavp_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_FIELD_BYTES = 32'd14;

  localparam logic [2:0] PH_SEEK_RIFF  = 3'd0;
  localparam logic [2:0] PH_FORM       = 3'd1;
  localparam logic [2:0] PH_SEEK_FMT   = 3'd2;
  localparam logic [2:0] PH_FMT_FIELDS = 3'd3;
  localparam logic [2:0] PH_SEEK_DATA  = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_RIFF      = 3'd1;
  localparam logic [2:0] ST_NO_FMT       = 3'd2;
  localparam logic [2:0] ST_NOT_PCM      = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd4;
  localparam logic [2:0] ST_NO_DATA      = 3'd5;
  localparam logic [2:0] ST_ZERO_SAMPLES = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } stage_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] block_align;
    logic [30:0] sample_count;
    logic [31:0] data_offset;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

// ===== rtl/wavp_byte_if.sv =====
// Byte channel: one file byte per item with an end-of-file mark.
interface wavp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/wavp_result_if.sv =====
// Result channel: one parsed header summary or error status per item.
interface wavp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channels;
  logic [31:0] rate_hz;
  logic [15:0] block_align;
  logic [30:0] sample_count;
  logic [31:0] data_offset;

  modport source (output valid, output status, output channels, output rate_hz,
                  output block_align, output sample_count, output data_offset,
                  input ready);
  modport sink (input valid, input status, input channels, input rate_hz,
                input block_align, input sample_count, input data_offset,
                output ready);
endinterface

// ===== rtl/wav_header_parser_top.sv =====
// Top level of the WAV header parser: input register, parser core, result buffer.
// Throughput: one byte per cycle unless the result buffer is full; the parser core updates all state per byte.
// A result is written into the result buffer when the core takes the byte that causes it.
// Two-entry result buffer: byte intake stops only when both entries are occupied.
// Synchronous reset, and every accepted last byte, return the parser to RIFF search.
module wav_header_parser_top #(
  parameter int OFFSET_BITS = wavp_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  wavp_byte_if.sink     bytes,
  wavp_result_if.source results
);

  wavp_pkg::stage_t stage;
  wavp_pkg::push_t  push;
  logic             full;
  logic             take;

  assign take = stage.valid && !full;

  wavp_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .stage (stage)
  );

  wavp_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .take  (take),
    .push  (push)
  );

  wavp_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .results (results)
  );

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> take)
    else $error("result pushed without a byte taken");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != wavp_pkg::ST_OK |->
      results.channels == '0 && results.rate_hz == '0 && results.block_align == '0 &&
      results.sample_count == '0 && results.data_offset == '0)
    else $error("error result carries nonzero fields");

  a_ok_fields_sane: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == wavp_pkg::ST_OK |->
      (results.block_align == 16'd1 || results.block_align == 16'd2) &&
      results.sample_count != '0)
    else $error("ok result with bad sample size or zero count");

endmodule

// ===== rtl/wavp_in_stage.sv =====
// Input register: holds one accepted byte until the parser core takes it.
module wavp_in_stage (
  input  logic             clk,
  input  logic             rst,
  wavp_byte_if.sink        bytes,
  input  logic             take,
  output wavp_pkg::stage_t stage
);

  logic                 valid;
  wavp_pkg::byte_item_t item;

  assign bytes.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.data_byte <= bytes.data_byte;
      item.last_byte <= bytes.last_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ===== rtl/wavp_core.sv =====
// Parser core: chunk walk, fmt field capture and result formation per byte.
module wavp_core #(
  parameter int OFFSET_BITS = wavp_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  wavp_pkg::stage_t stage,
  input  logic             take,
  output wavp_pkg::push_t  push
);

  logic [2:0]             phase, phase_next;
  logic [3:0]             hbc, hbc_next;
  logic [31:0]            tag, tag_next;
  logic [31:0]            len, len_next;
  logic [31:0]            skip, skip_next;
  logic [OFFSET_BITS-1:0] file_offset, file_offset_next, offset_inc;
  logic [31:0]            accum, accum_next;
  logic [15:0]            channels, channels_next;
  logic [31:0]            rate, rate_next;
  logic [15:0]            size, size_next;
  logic                   done, done_next;

  logic [7:0]  b;
  logic [31:0] want;
  logic [31:0] w_tag, w_len, w_skip, w_pad;
  logic [3:0]  w_hbc;
  logic [2:0]  w_n;
  logic        w_neg, w_hit;
  logic [1:0]  sh;
  logic [31:0] fmt_pad;
  logic [30:0] count;
  logic        emit;
  logic [2:0]  emit_status;

  assign b          = stage.item.data_byte;
  assign offset_inc = file_offset + 1'b1;

  always_comb begin
    priority case (phase)
      wavp_pkg::PH_SEEK_RIFF: want = wavp_pkg::TAG_RIFF;
      wavp_pkg::PH_SEEK_FMT:  want = wavp_pkg::TAG_FMT;
      default:                want = wavp_pkg::TAG_DATA;
    endcase
  end

  // Generic chunk walk over one byte: skip body, else gather tag and length.
  always_comb begin
    w_tag  = tag;
    w_len  = len;
    w_skip = skip;
    w_hbc  = hbc;
    w_neg  = 1'b0;
    w_hit  = 1'b0;
    w_n    = hbc[2:0];
    w_pad  = '0;
    if (skip != '0) begin
      w_skip = skip - 1'b1;
    end else begin
      if (!w_n[2]) begin
        w_tag = {tag[23:0], b};
      end else begin
        unique case (w_n[1:0])
          2'd0: w_len = {24'd0, b};
          2'd1: w_len = {len[31:16], b, len[7:0]};
          2'd2: w_len = {len[31:24], b, len[15:0]};
          2'd3: w_len = {b, len[23:0]};
        endcase
      end
      if (w_n != 3'd7) begin
        w_hbc = {1'b0, w_n + 3'd1};
      end else begin
        w_hbc = '0;
        w_pad = w_len + {31'd0, w_len[0]};
        if (w_len[31]) begin
          w_neg = 1'b1;
        end else if (w_tag == want) begin
          w_hit = 1'b1;
        end else begin
          w_skip = w_pad;
        end
      end
    end
  end

  assign sh      = (hbc >= 4'd4 && hbc < 4'd12) ? hbc[1:0] : {1'b0, hbc[0]};
  assign fmt_pad = len + {31'd0, len[0]};
  assign count   = (size == 16'd2) ? w_len[31:1] : w_len[30:0];

  always_comb begin
    phase_next       = phase;
    hbc_next         = hbc;
    tag_next         = tag;
    len_next         = len;
    skip_next        = skip;
    file_offset_next = offset_inc;
    accum_next       = accum;
    channels_next    = channels;
    rate_next        = rate;
    size_next        = size;
    done_next        = done;
    emit             = 1'b0;
    emit_status      = wavp_pkg::ST_OK;

    if (!done) begin
      unique case (phase)
        wavp_pkg::PH_SEEK_RIFF, wavp_pkg::PH_SEEK_FMT, wavp_pkg::PH_SEEK_DATA: begin
          tag_next  = w_tag;
          len_next  = w_len;
          skip_next = w_skip;
          hbc_next  = w_hbc;
          if (w_neg) begin
            emit = 1'b1;
            if (phase == wavp_pkg::PH_SEEK_RIFF) begin
              emit_status = wavp_pkg::ST_NO_RIFF;
            end else if (phase == wavp_pkg::PH_SEEK_FMT) begin
              emit_status = wavp_pkg::ST_NO_FMT;
            end else begin
              emit_status = wavp_pkg::ST_NO_DATA;
            end
          end else if (w_hit) begin
            if (phase == wavp_pkg::PH_SEEK_RIFF) begin
              phase_next = wavp_pkg::PH_FORM;
            end else if (phase == wavp_pkg::PH_SEEK_FMT) begin
              phase_next = wavp_pkg::PH_FMT_FIELDS;
            end else begin
              emit        = 1'b1;
              emit_status = (count == '0) ? wavp_pkg::ST_ZERO_SAMPLES : wavp_pkg::ST_OK;
            end
          end
        end
        wavp_pkg::PH_FORM: begin
          tag_next = {tag[23:0], b};
          hbc_next = hbc + 4'd1;
          if (hbc == 4'd3) begin
            hbc_next = '0;
            if (tag_next != wavp_pkg::TAG_WAVE) begin
              emit        = 1'b1;
              emit_status = wavp_pkg::ST_NO_RIFF;
            end else begin
              phase_next = wavp_pkg::PH_SEEK_FMT;
              skip_next  = '0;
            end
          end
        end
        wavp_pkg::PH_FMT_FIELDS: begin
          unique case (sh)
            2'd0: accum_next = {24'd0, b};
            2'd1: accum_next = {accum[31:16], b, accum[7:0]};
            2'd2: accum_next = {accum[31:24], b, accum[15:0]};
            2'd3: accum_next = {b, accum[23:0]};
          endcase
          hbc_next = hbc + 4'd1;
          if (hbc == 4'd1 && accum_next[15:0] != 16'd1) begin
            emit        = 1'b1;
            emit_status = wavp_pkg::ST_NOT_PCM;
          end
          if (hbc == 4'd3) channels_next = accum_next[15:0];
          if (hbc == 4'd7) rate_next = accum_next;
          if (hbc == 4'd13) begin
            size_next = accum_next[15:0];
            if (size_next != 16'd1 && size_next != 16'd2) begin
              emit        = 1'b1;
              emit_status = wavp_pkg::ST_BAD_SIZE;
            end else begin
              hbc_next   = '0;
              skip_next  = (fmt_pad > wavp_pkg::FMT_FIELD_BYTES) ?
                           fmt_pad - wavp_pkg::FMT_FIELD_BYTES : '0;
              phase_next = wavp_pkg::PH_SEEK_DATA;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (stage.item.last_byte) begin
      if (!done && !emit) begin
        emit = 1'b1;
        if (phase_next == wavp_pkg::PH_SEEK_RIFF || phase_next == wavp_pkg::PH_FORM) begin
          emit_status = wavp_pkg::ST_NO_RIFF;
        end else if (phase_next == wavp_pkg::PH_SEEK_DATA) begin
          emit_status = wavp_pkg::ST_NO_DATA;
        end else begin
          emit_status = wavp_pkg::ST_NO_FMT;
        end
      end
      phase_next       = wavp_pkg::PH_SEEK_RIFF;
      hbc_next         = '0;
      skip_next        = '0;
      file_offset_next = '0;
      done_next        = 1'b0;
    end else if (emit) begin
      done_next = 1'b1;
    end
  end

  always_comb begin
    push           = '0;
    push.valid     = take && emit;
    push.res.status = emit_status;
    if (emit_status == wavp_pkg::ST_OK) begin
      push.res.channels     = channels;
      push.res.rate_hz      = rate;
      push.res.block_align  = size;
      push.res.sample_count = count;
      push.res.data_offset  = 32'(offset_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= wavp_pkg::PH_SEEK_RIFF;
      hbc         <= '0;
      skip        <= '0;
      file_offset <= '0;
      done        <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      hbc         <= hbc_next;
      skip        <= skip_next;
      file_offset <= file_offset_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag      <= tag_next;
      len      <= len_next;
      accum    <= accum_next;
      channels <= channels_next;
      rate     <= rate_next;
      size     <= size_next;
    end
  end

endmodule

// ===== rtl/wavp_out_buf.sv =====
// Result register with a skid entry, so the core waits on the sink only while the skid entry is occupied.
module wavp_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  wavp_pkg::push_t push,
  output logic            full,
  wavp_result_if.source   results
);

  logic              main_valid;
  logic              skid_valid;
  wavp_pkg::result_t main_res;
  wavp_pkg::result_t skid_res;
  logic              pop;

  assign pop  = main_valid && results.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_res <= push.res;
      end else begin
        skid_res <= push.res;
      end
    end
  end

  assign results.valid        = main_valid;
  assign results.status       = main_res.status;
  assign results.channels     = main_res.channels;
  assign results.rate_hz      = main_res.rate_hz;
  assign results.block_align  = main_res.block_align;
  assign results.sample_count = main_res.sample_count;
  assign results.data_offset  = main_res.data_offset;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the WAV header parser: byte stream in, header results checked.
module tb_top;

  localparam int IDLE_MAX     = 14;
  localparam int BYTE_TARGET  = 1350;
  localparam int FILE_TARGET  = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 1200;

  logic clk;
  logic rst;

  wavp_byte_if byte_ch ();
  wavp_result_if result_ch ();

  wav_header_parser_top u_dut (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .results(result_ch)
  );

  logic [2:0]  ph;
  logic [3:0]  hdr_n;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] skip_left;
  logic [31:0] byte_pos;
  logic [31:0] field_acc;
  logic [15:0] fmt_channels;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_size;
  bit          reported;

  wavp_pkg::byte_item_t pending_bytes[$];
  wavp_pkg::result_t    expected_headers[$];
  logic [7:0]           file_buf[$];

  int bytes_sent = 0;
  int bytes_total = 0;
  int files_total = 0;
  int headers_checked = 0;
  int mismatches = 0;
  int cycles = 0;
  int status_seen[7];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function void parser_clear();
    ph = wavp_pkg::PH_SEEK_RIFF;
    hdr_n = '0;
    tag_acc = '0;
    chunk_len = '0;
    skip_left = '0;
    byte_pos = '0;
    field_acc = '0;
    fmt_channels = '0;
    fmt_rate = '0;
    fmt_size = '0;
    reported = 1'b0;
  endfunction

  function automatic wavp_pkg::result_t header_result(logic [2:0] st, logic [30:0] cnt,
                                                      logic [31:0] off);
    wavp_pkg::result_t r;
    r = '0;
    r.status = st;
    if (st == wavp_pkg::ST_OK) begin
      r.channels = fmt_channels;
      r.rate_hz = fmt_rate;
      r.block_align = fmt_size;
      r.sample_count = cnt;
      r.data_offset = off;
    end
    reported = 1'b1;
    return r;
  endfunction

  // 1: wanted chunk header complete, -1: negative length, 0: keep walking
  function automatic int chunk_walk(logic [7:0] b, logic [31:0] want);
    int n;
    n = hdr_n[2:0];
    if (skip_left != 0) begin
      skip_left--;
      return 0;
    end
    if (n < 4) tag_acc = {tag_acc[23:0], b};
    else if (n == 4) chunk_len = {24'd0, b};
    else chunk_len = chunk_len | (32'(b) << (8 * (n - 4)));
    n++;
    if (n < 8) begin
      hdr_n = 4'(n);
      return 0;
    end
    hdr_n = '0;
    if (chunk_len[31]) return -1;
    if (tag_acc == want) return 1;
    skip_left = (chunk_len + 32'd1) & ~32'd1;
    return 0;
  endfunction

  function automatic bit header_predict(logic [7:0] b, logic last,
                                        output wavp_pkg::result_t r);
    bit hit;
    int w;
    int pos;
    int sh;
    logic [31:0] padded;
    logic [31:0] cnt;
    logic [2:0] st;
    hit = 1'b0;
    r = '0;
    if (!reported) begin
      case (ph)
        wavp_pkg::PH_SEEK_RIFF: begin
          w = chunk_walk(b, wavp_pkg::TAG_RIFF);
          if (w < 0) begin
            r = header_result(wavp_pkg::ST_NO_RIFF, '0, '0);
            hit = 1'b1;
          end else if (w > 0) begin
            ph = wavp_pkg::PH_FORM;
            tag_acc = '0;
          end
        end
        wavp_pkg::PH_FORM: begin
          tag_acc = {tag_acc[23:0], b};
          hdr_n++;
          if (hdr_n == 4'd4) begin
            hdr_n = '0;
            if (tag_acc != wavp_pkg::TAG_WAVE) begin
              r = header_result(wavp_pkg::ST_NO_RIFF, '0, '0);
              hit = 1'b1;
            end else begin
              ph = wavp_pkg::PH_SEEK_FMT;
              skip_left = '0;
            end
          end
        end
        wavp_pkg::PH_SEEK_FMT: begin
          w = chunk_walk(b, wavp_pkg::TAG_FMT);
          if (w < 0) begin
            r = header_result(wavp_pkg::ST_NO_FMT, '0, '0);
            hit = 1'b1;
          end else if (w > 0) begin
            ph = wavp_pkg::PH_FMT_FIELDS;
            field_acc = '0;
          end
        end
        wavp_pkg::PH_FMT_FIELDS: begin
          pos = hdr_n;
          sh = (pos >= 4 && pos < 12) ? pos % 4 : pos % 2;
          if (sh == 0) field_acc = {24'd0, b};
          else field_acc = field_acc | (32'(b) << (8 * sh));
          hdr_n = 4'(pos + 1);
          if (pos == 1 && field_acc[15:0] != 16'd1) begin
            r = header_result(wavp_pkg::ST_NOT_PCM, '0, '0);
            hit = 1'b1;
          end else begin
            if (pos == 3) fmt_channels = field_acc[15:0];
            if (pos == 7) fmt_rate = field_acc;
            if (pos == 13) begin
              fmt_size = field_acc[15:0];
              if (fmt_size != 16'd1 && fmt_size != 16'd2) begin
                r = header_result(wavp_pkg::ST_BAD_SIZE, '0, '0);
                hit = 1'b1;
              end else begin
                hdr_n = '0;
                padded = (chunk_len + 32'd1) & ~32'd1;
                skip_left = (padded > wavp_pkg::FMT_FIELD_BYTES) ?
                            padded - wavp_pkg::FMT_FIELD_BYTES : '0;
                ph = wavp_pkg::PH_SEEK_DATA;
              end
            end
          end
        end
        wavp_pkg::PH_SEEK_DATA: begin
          w = chunk_walk(b, wavp_pkg::TAG_DATA);
          if (w < 0) begin
            r = header_result(wavp_pkg::ST_NO_DATA, '0, '0);
            hit = 1'b1;
          end else if (w > 0) begin
            cnt = (fmt_size == 16'd2) ? chunk_len >> 1 : chunk_len;
            if (cnt == 0) r = header_result(wavp_pkg::ST_ZERO_SAMPLES, '0, '0);
            else r = header_result(wavp_pkg::ST_OK, cnt[30:0], byte_pos + 32'd1);
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    byte_pos++;
    if (last) begin
      if (!reported) begin
        if (ph == wavp_pkg::PH_SEEK_RIFF || ph == wavp_pkg::PH_FORM) st = wavp_pkg::ST_NO_RIFF;
        else if (ph == wavp_pkg::PH_SEEK_DATA) st = wavp_pkg::ST_NO_DATA;
        else st = wavp_pkg::ST_NO_FMT;
        r = header_result(st, '0, '0);
        hit = 1'b1;
      end
      parser_clear();
    end
    return hit;
  endfunction

  function automatic int idle_draw(inout int calm);
    int g;
    if (calm > 0) begin
      calm--;
      g = 0;
    end else begin
      g = $urandom_range(0, IDLE_MAX);
      if ($urandom_range(0, 31) == 0) calm = $urandom_range(20, 80);
    end
    return g;
  endfunction

  function automatic logic [31:0] maybe_corrupt(logic [31:0] t);
    if ($urandom_range(0, 19) == 0) return t ^ (32'd1 << $urandom_range(0, 31));
    return t;
  endfunction

  function void put_le(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) file_buf.push_back(v[8 * i +: 8]);
  endfunction

  function void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_buf.push_back(t[8 * i +: 8]);
  endfunction

  function void put_chunk(logic [31:0] t);
    logic [31:0] len;
    len = ($urandom_range(0, 29) == 0) ? {1'b1, 31'($urandom)} : 32'($urandom_range(0, 6));
    put_tag(t);
    put_le(len, 4);
    if (!len[31]) repeat ((len + 1) & ~32'd1) file_buf.push_back(8'($urandom));
  endfunction

  function void close_file();
    wavp_pkg::byte_item_t it;
    while (file_buf.size() != 0) begin
      it.data_byte = file_buf.pop_front();
      it.last_byte = (file_buf.size() == 0);
      pending_bytes.push_back(it);
      bytes_total++;
    end
    files_total++;
  endfunction

  task automatic random_file();
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    logic [31:0] padded;
    logic [15:0] align;
    int cut;
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 30)) file_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 1)) put_chunk($urandom);
      put_tag(maybe_corrupt(wavp_pkg::TAG_RIFF));
      put_le(($urandom_range(0, 19) == 0) ? {1'b1, 31'($urandom)} : {1'b0, 31'($urandom)}, 4);
      put_tag(maybe_corrupt(wavp_pkg::TAG_WAVE));
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 2) == 0) put_chunk(wavp_pkg::TAG_DATA);
        else put_chunk($urandom);
      end
      case ($urandom_range(0, 9))
        0: fmt_len = $urandom_range(0, 13);
        1: fmt_len = 32'd15;
        2: fmt_len = 32'd17;
        3: fmt_len = 32'd18;
        4: fmt_len = 32'd14;
        5: fmt_len = {1'b1, 31'($urandom)};
        default: fmt_len = 32'd16;
      endcase
      put_tag(maybe_corrupt(wavp_pkg::TAG_FMT));
      put_le(fmt_len, 4);
      put_le(($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 65535)) : 32'd1, 2);
      put_le($urandom, 2);
      case ($urandom_range(0, 9))
        0: put_le(32'd0, 4);
        1: put_le(32'hFFFF_FFFF, 4);
        default: put_le($urandom, 4);
      endcase
      put_le($urandom, 4);
      case ($urandom_range(0, 9))
        0: align = 16'd0;
        1: align = 16'hFFFF;
        2: align = 16'($urandom);
        3: align = 16'd3;
        default: align = 16'($urandom_range(1, 2));
      endcase
      put_le(32'(align), 2);
      padded = (fmt_len + 32'd1) & ~32'd1;
      if (!fmt_len[31] && padded > wavp_pkg::FMT_FIELD_BYTES)
        repeat (padded - wavp_pkg::FMT_FIELD_BYTES) file_buf.push_back(8'($urandom));
      repeat ($urandom_range(0, 1)) put_chunk($urandom);
      case ($urandom_range(0, 9))
        0: data_len = 32'd0;
        1: data_len = 32'd1;
        2: data_len = 32'h7FFF_FFFF;
        3: data_len = 32'hFFFF_FFFF;
        4: data_len = {1'b1, 31'($urandom)};
        5: data_len = {1'b0, 31'($urandom)};
        default: data_len = $urandom_range(2, 64);
      endcase
      put_tag(maybe_corrupt(wavp_pkg::TAG_DATA));
      put_le(data_len, 4);
      repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, file_buf.size());
        while (file_buf.size() > cut) void'(file_buf.pop_back());
      end
    end
    close_file();
  endtask

  int src_gap;
  int src_calm = 0;

  always @(posedge clk) begin
    wavp_pkg::byte_item_t nxt;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (src_gap > 0) begin
        src_gap--;
        byte_ch.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= nxt.data_byte;
        byte_ch.last_byte <= nxt.last_byte;
        src_gap = idle_draw(src_calm);
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  logic hold_results;
  int   hold_clock;
  int   hold_left;

  always @(posedge clk) begin
    if (rst) begin
      hold_results <= 1'b0;
      hold_clock <= 0;
      hold_left <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_clock == HOLD_START) begin
        hold_results <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        hold_results <= 1'b0;
      end
    end
  end

  int sink_wait;
  int sink_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) sink_wait = idle_draw(sink_calm);
      if (hold_results) begin
        result_ch.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    wavp_pkg::result_t got;
    wavp_pkg::result_t want;
    wavp_pkg::result_t pred;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.status = result_ch.status;
        got.channels = result_ch.channels;
        got.rate_hz = result_ch.rate_hz;
        got.block_align = result_ch.block_align;
        got.sample_count = result_ch.sample_count;
        got.data_offset = result_ch.data_offset;
        if (expected_headers.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result at cycle %0d: status %0d", cycles, got.status);
          mismatches++;
        end else begin
          want = expected_headers.pop_front();
          headers_checked++;
          status_seen[want.status]++;
          if (got.status !== want.status || got.channels !== want.channels ||
              got.rate_hz !== want.rate_hz || got.block_align !== want.block_align ||
              got.sample_count !== want.sample_count ||
              got.data_offset !== want.data_offset) begin
            if (mismatches < 10) begin
              $display("Mismatch on header %0d (st/ch/rate/size/count/offset):",
                       headers_checked);
              $display("  expected %0d/%h/%h/%h/%h/%h", want.status, want.channels,
                       want.rate_hz, want.block_align, want.sample_count, want.data_offset);
              $display("  actual   %0d/%h/%h/%h/%h/%h", got.status, got.channels,
                       got.rate_hz, got.block_align, got.sample_count, got.data_offset);
            end
            mismatches++;
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_sent++;
        if (header_predict(byte_ch.data_byte, byte_ch.last_byte, pred))
          expected_headers.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d of %0d bytes sent, %0d results outstanding",
               cycles, bytes_sent, bytes_total, expected_headers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    result_ch.ready = 1'b0;
    parser_clear();

    file_buf.push_back(8'h00);
    close_file();
    put_tag(wavp_pkg::TAG_RIFF);
    put_le(32'hFFFF_FFFF, 4);
    file_buf.push_back(8'hFF);
    close_file();
    put_tag(wavp_pkg::TAG_RIFF);
    put_le(32'd4, 4);
    put_tag(wavp_pkg::TAG_WAVE ^ 32'd1);
    close_file();

    while (bytes_total < BYTE_TARGET || files_total < FILE_TARGET) random_file();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent != bytes_total || expected_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_headers.size();

    $display("Sent %0d bytes in %0d files, checked %0d results, receiver held off %0d cycles",
             bytes_sent, files_total, headers_checked, HOLD_CYCLES);
    $display("Status ok/RIFF/fmt/PCM/size/data/zero: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wavp_pkg.sv
rtl/wavp_byte_if.sv
rtl/wavp_result_if.sv
rtl/wavp_in_stage.sv
rtl/wavp_core.sv
rtl/wavp_out_buf.sv
rtl/wav_header_parser_top.sv
bench/tb_top.sv
